/* src/wvg_pkg.sv */
// ---------------------------------------------------------------------------
// wvg_pkg: shared definitions for the windowed volatility guard
// Widths, register indexes, codes and the divider beat types used by the
// guard and its divider.
// ---------------------------------------------------------------------------
package wvg_pkg;

   localparam int WINDOW_DEPTH = 256;
   localparam int IDX_W        = $clog2(WINDOW_DEPTH);
   localparam int CNT_W        = $clog2(WINDOW_DEPTH) + 1;
   localparam int PRICE_BITS   = 48;
   localparam int FRAC_BITS    = 32;
   localparam int INT_BITS     = 8;
   localparam int RATIO_W      = FRAC_BITS + INT_BITS;
   localparam int TIME_W       = 64;
   localparam int CSR_W        = 64;
   localparam int CSR_IDX_W    = 3;
   localparam int COUNTER_W    = 32;
   localparam int LIMIT_W      = 16;
   localparam int JUMPS_W      = 9;

   localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
   localparam logic [TIME_W-1:0]  TIME_BIAS = {1'b1, {(TIME_W-1){1'b0}}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_THRESHOLD      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_COUNT_LIMIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_WINDOW_NS      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE_WINDOW_NS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN_NS         = 3'd5;

   // operations
   localparam logic OP_QUOTE = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   // block reasons
   localparam logic [1:0] REASON_NONE     = 2'd0;
   localparam logic [1:0] REASON_COOLDOWN = 2'd1;
   localparam logic [1:0] REASON_TRIGGER  = 2'd2;

   typedef struct packed {
      logic                  start;
      logic [PRICE_BITS-1:0] num;
      logic [PRICE_BITS-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [RATIO_W-1:0] quo;
   } div_rsp_type;

endpackage

/* src/wvg_ram.sv */
// ---------------------------------------------------------------------------
// wvg_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module wvg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* src/wvg_div.sv */
// ---------------------------------------------------------------------------
// wvg_div: iterative Q8.32 ratio divider
// Restoring division, one quotient bit a cycle, saturating at the ratio max.
// ---------------------------------------------------------------------------
module wvg_div (
   input  logic                 clock,
   input  logic                 reset,
   input  wvg_pkg::div_req_type req,
   output wvg_pkg::div_rsp_type rsp
);

   localparam int REM_W  = wvg_pkg::PRICE_BITS + 1;
   localparam int STEP_W = $clog2(wvg_pkg::RATIO_W);

   typedef enum logic [0:0] {DV_IDLE, DV_RUN} dv_state_type;

   dv_state_type                      state_ff, state_in;
   logic [REM_W-1:0]                  rem_ff, rem_in;
   logic [wvg_pkg::RATIO_W-1:0]       shift_ff, shift_in;
   logic [wvg_pkg::RATIO_W-1:0]       quo_ff, quo_in;
   logic [wvg_pkg::PRICE_BITS-1:0]    den_ff, den_in;
   logic [STEP_W-1:0]                 step_ff, step_in;
   logic                              done_ff, done_in;
   logic [REM_W-1:0]                  trial;
   logic                              fits;
   logic                              overflow;

   // integer part of 256 or more saturates
   assign overflow = {{wvg_pkg::INT_BITS{1'b0}}, req.num} >=
                     {req.den, {wvg_pkg::INT_BITS{1'b0}}};
   assign trial    = {rem_ff[REM_W-2:0], shift_ff[wvg_pkg::RATIO_W-1]};
   assign fits     = trial >= {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      case (state_ff)
         DV_IDLE: begin
            if (req.start) begin
               if (overflow) begin
                  quo_in  = wvg_pkg::RATIO_MAX;
                  done_in = 1'b1;
               end else begin
                  rem_in   = {{(REM_W-wvg_pkg::PRICE_BITS+wvg_pkg::INT_BITS){1'b0}},
                              req.num[wvg_pkg::PRICE_BITS-1:wvg_pkg::INT_BITS]};
                  shift_in = {req.num[wvg_pkg::INT_BITS-1:0], {wvg_pkg::FRAC_BITS{1'b0}}};
                  den_in   = req.den;
                  quo_in   = '0;
                  step_in  = '0;
                  state_in = DV_RUN;
               end
            end
         end
         DV_RUN: begin
            // shift in one numerator bit, subtract where it fits
            rem_in   = fits ? trial - {1'b0, den_ff} : trial;
            quo_in   = {quo_ff[wvg_pkg::RATIO_W-2:0], fits};
            shift_in = {shift_ff[wvg_pkg::RATIO_W-2:0], 1'b0};
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(wvg_pkg::RATIO_W - 1)) begin
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      step_ff  <= step_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

/* src/windowed_volatility_guard.sv */
// ---------------------------------------------------------------------------
// windowed_volatility_guard: volatility guard for a quoted market
// Quotes feed two time-windowed stores (relative moves and mids); a check
// counts jumps and the max/min amplitude and decides whether to block.
// ---------------------------------------------------------------------------
// One item is in flight at a time. req_ready stays low until the response
// beat for that item is taken.
// Steps from the request beat to the response beat:
//  - An invalid quote, a first quote or a quote with an unchanged mid goes
//    from decode straight to the response.
//  - A quote whose mid changes waits for the ratio divide, then runs a trim
//    pass; each trimmed entry takes a read step and a compare step.
//  - A check runs the trim pass, then, when its time is positive, walks each
//    entry of the larger store and runs the amplitude divide when two or more
//    mids remain. A check whose time is not positive goes to the response
//    after the trim pass.
// After the response beat the guard returns to idle before it takes the next
// request beat. These steps come from the registered store read ports and
// the one shared bit-serial divider. Both stores hold 256 entries.
// ---------------------------------------------------------------------------
module windowed_volatility_guard (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic signed [wvg_pkg::TIME_W-1:0]    req_event_time,
   input  logic signed [wvg_pkg::PRICE_BITS-1:0] req_bid_price,
   input  logic signed [wvg_pkg::PRICE_BITS-1:0] req_ask_price,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_blocked,
   output logic [1:0]                           rsp_block_reason,
   output logic [wvg_pkg::JUMPS_W-1:0]          rsp_jumps_in_window,
   output logic [wvg_pkg::RATIO_W-1:0]          rsp_amplitude,
   output logic                                 rsp_hot,
   output logic                                 rsp_cooling,
   output logic [wvg_pkg::TIME_W-1:0]           rsp_cooldown_end,
   output logic [wvg_pkg::COUNTER_W-1:0]        rsp_skipped_total,
   output logic [wvg_pkg::COUNTER_W-1:0]        rsp_out_of_order_total,
   output logic                                 rsp_store_overflow,
   input  logic                                 csr_wr_en,
   input  logic [wvg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wvg_pkg::CSR_W-1:0]            csr_wdata
);

   localparam int TW   = wvg_pkg::TIME_W;
   localparam int PW   = wvg_pkg::PRICE_BITS;
   localparam int RW   = wvg_pkg::RATIO_W;
   localparam int IW   = wvg_pkg::IDX_W;
   localparam int CW   = wvg_pkg::CNT_W;
   localparam int RETW = TW + RW;
   localparam int MIDW = TW + PW;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_DIV_Q, S_TRIM_RD, S_TRIM_CMP,
      S_WALK, S_AMP, S_DIV_A, S_DECIDE, S_RESP
   } state_type;

   // configuration
   logic [RW-1:0]                jthr_ff;
   logic [wvg_pkg::LIMIT_W-1:0]  jlim_ff;
   logic [TW-1:0]                jwin_ff;
   logic [RW-1:0]                athr_ff;
   logic [TW-1:0]                awin_ff;
   logic [TW-1:0]                cool_ns_ff;

   // sequencer and item state
   state_type                    state_ff, state_in;
   logic                         op_ff, op_in;
   logic [TW-1:0]                time_ff, time_in;
   logic [PW-1:0]                mid_ff, mid_in;
   logic                         qvalid_ff, qvalid_in;
   logic [PW-1:0]                prev_mid_ff, prev_mid_in;
   logic                         prev_valid_ff, prev_valid_in;
   logic [TW-1:0]                last_qt_ff, last_qt_in;
   logic [TW-1:0]                cooldown_ff, cooldown_in;
   logic [wvg_pkg::COUNTER_W-1:0] skip_ff, skip_in;
   logic [wvg_pkg::COUNTER_W-1:0] ooo_ff, ooo_in;
   logic                         ovf_ff, ovf_in;
   logic [IW-1:0]                r_head_ff, r_head_in, m_head_ff, m_head_in;
   logic [CW-1:0]                r_cnt_ff, r_cnt_in, m_cnt_ff, m_cnt_in;
   logic [TW-1:0]                r_cut_ff, r_cut_in, m_cut_ff, m_cut_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic                         pend_ff, pend_in;
   logic                         pend_r_ff, pend_r_in;
   logic                         pend_m_ff, pend_m_in;
   logic                         pend_first_ff, pend_first_in;
   logic [PW-1:0]                lo_ff, lo_in, hi_ff, hi_in;
   logic [wvg_pkg::JUMPS_W-1:0]  jumps_ff, jumps_in;
   logic [RW-1:0]                amp_ff, amp_in;
   logic                         block_ff, block_in;
   logic [1:0]                   reason_ff, reason_in;
   logic                         hot_ff, hot_in;
   logic                         active_ff, active_in;

   // store ports
   logic                         r_wr_en, m_wr_en;
   logic [IW-1:0]                r_wr_addr, m_wr_addr, r_rd_addr, m_rd_addr;
   logic [RETW-1:0]              r_wr_data, r_rd_data;
   logic [MIDW-1:0]              m_wr_data, m_rd_data;

   wvg_pkg::div_req_type         div_req;
   wvg_pkg::div_rsp_type         div_rsp;

   // helpers
   logic [PW-1:0]                diff;
   logic [TW-1:0]                now_biased;
   logic                         r_full, m_full, r_drop, m_drop;
   logic [CW-1:0]                max_cnt;
   logic [TW:0]                  cool_sum;
   logic [PW-1:0]                m_val;
   logic                         hot_now, active_now, time_pos;

   wvg_ram #(.WIDTH(RETW), .DEPTH(wvg_pkg::WINDOW_DEPTH)) u_ret_ram (
      .clock   (clock),
      .wr_en   (r_wr_en),
      .wr_addr (r_wr_addr),
      .wr_data (r_wr_data),
      .rd_addr (r_rd_addr),
      .rd_data (r_rd_data)
   );

   wvg_ram #(.WIDTH(MIDW), .DEPTH(wvg_pkg::WINDOW_DEPTH)) u_mid_ram (
      .clock   (clock),
      .wr_en   (m_wr_en),
      .wr_addr (m_wr_addr),
      .wr_data (m_wr_data),
      .rd_addr (m_rd_addr),
      .rd_data (m_rd_data)
   );

   wvg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         jthr_ff    <= '0;
         jlim_ff    <= '0;
         jwin_ff    <= '0;
         athr_ff    <= '0;
         awin_ff    <= '0;
         cool_ns_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            wvg_pkg::CSR_JUMP_THRESHOLD:      jthr_ff    <= csr_wdata[RW-1:0];
            wvg_pkg::CSR_JUMP_COUNT_LIMIT:    jlim_ff    <= csr_wdata[wvg_pkg::LIMIT_W-1:0];
            wvg_pkg::CSR_JUMP_WINDOW_NS:      jwin_ff    <= csr_wdata;
            wvg_pkg::CSR_AMPLITUDE_THRESHOLD: athr_ff    <= csr_wdata[RW-1:0];
            wvg_pkg::CSR_AMPLITUDE_WINDOW_NS: awin_ff    <= csr_wdata;
            wvg_pkg::CSR_COOLDOWN_NS:         cool_ns_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // shared combinational terms
   assign diff       = (mid_ff > prev_mid_ff) ? mid_ff - prev_mid_ff : prev_mid_ff - mid_ff;
   assign now_biased = time_ff ^ wvg_pkg::TIME_BIAS;
   assign r_full     = r_cnt_ff == CW'(wvg_pkg::WINDOW_DEPTH);
   assign m_full     = m_cnt_ff == CW'(wvg_pkg::WINDOW_DEPTH);
   assign r_drop     = (r_cnt_ff != '0) &&
                       ((r_rd_data[RETW-1:RW] ^ wvg_pkg::TIME_BIAS) < r_cut_ff);
   assign m_drop     = (m_cnt_ff != '0) &&
                       ((m_rd_data[MIDW-1:PW] ^ wvg_pkg::TIME_BIAS) < m_cut_ff);
   assign max_cnt    = (r_cnt_ff > m_cnt_ff) ? r_cnt_ff : m_cnt_ff;
   assign cool_sum   = {1'b0, time_ff} + {1'b0, cool_ns_ff};
   assign m_val      = m_rd_data[PW-1:0];
   assign time_pos   = (time_ff != '0) && !time_ff[TW-1];
   assign hot_now    = ({{(wvg_pkg::LIMIT_W-wvg_pkg::JUMPS_W){1'b0}}, jumps_ff} >= jlim_ff)
                       || (amp_ff > athr_ff);
   assign active_now = time_ff < cooldown_ff;

   // read at the head while trimming, at head plus index while walking
   assign r_rd_addr  = (state_ff == S_WALK) ? r_head_ff + idx_ff[IW-1:0] : r_head_ff;
   assign m_rd_addr  = (state_ff == S_WALK) ? m_head_ff + idx_ff[IW-1:0] : m_head_ff;

   // push slot: a full store overwrites its oldest entry
   assign r_wr_addr  = r_full ? r_head_ff : r_head_ff + r_cnt_ff[IW-1:0];
   assign m_wr_addr  = m_full ? m_head_ff : m_head_ff + m_cnt_ff[IW-1:0];
   assign r_wr_data  = {time_ff, div_rsp.quo};
   assign m_wr_data  = {time_ff, mid_ff};
   assign r_wr_en    = (state_ff == S_DIV_Q) && div_rsp.done;
   assign m_wr_en    = r_wr_en;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      time_in       = time_ff;
      mid_in        = mid_ff;
      qvalid_in     = qvalid_ff;
      prev_mid_in   = prev_mid_ff;
      prev_valid_in = prev_valid_ff;
      last_qt_in    = last_qt_ff;
      cooldown_in   = cooldown_ff;
      skip_in       = skip_ff;
      ooo_in        = ooo_ff;
      ovf_in        = ovf_ff;
      r_head_in     = r_head_ff;
      r_cnt_in      = r_cnt_ff;
      m_head_in     = m_head_ff;
      m_cnt_in      = m_cnt_ff;
      r_cut_in      = r_cut_ff;
      m_cut_in      = m_cut_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_r_in     = pend_r_ff;
      pend_m_in     = pend_m_ff;
      pend_first_in = pend_first_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      jumps_in      = jumps_ff;
      amp_in        = amp_ff;
      block_in      = block_ff;
      reason_in     = reason_ff;
      hot_in        = hot_ff;
      active_in     = active_ff;
      div_req.start = 1'b0;
      div_req.num   = diff;
      div_req.den   = prev_mid_ff;

      case (state_ff)
         S_IDLE: begin
            // capture the beat, its mid and whether the quote is usable
            if (req_valid) begin
               op_in     = req_operation;
               time_in   = req_event_time;
               mid_in    = req_bid_price + req_ask_price;
               qvalid_in = (req_event_time > 0) && (req_bid_price > 0) &&
                           (req_ask_price > 0);
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            block_in  = 1'b0;
            reason_in = wvg_pkg::REASON_NONE;
            jumps_in  = '0;
            amp_in    = '0;
            hot_in    = 1'b0;
            active_in = 1'b0;
            // trim bounds, saturating at the oldest time
            r_cut_in  = (jwin_ff >= now_biased) ? '0 : now_biased - jwin_ff;
            m_cut_in  = (awin_ff >= now_biased) ? '0 : now_biased - awin_ff;
            if (op_ff == wvg_pkg::OP_CHECK) begin
               state_in = S_TRIM_RD;
            end else if (!qvalid_ff) begin
               skip_in  = (skip_ff == '1) ? skip_ff : skip_ff + 1'b1;
               state_in = S_RESP;
            end else begin
               if ((last_qt_ff != '0) && (time_ff < last_qt_ff)) begin
                  ooo_in = (ooo_ff == '1) ? ooo_ff : ooo_ff + 1'b1;
               end
               last_qt_in = time_ff;
               if (!prev_valid_ff) begin
                  prev_mid_in   = mid_ff;
                  prev_valid_in = 1'b1;
                  state_in      = S_RESP;
               end else if (mid_ff == prev_mid_ff) begin
                  state_in = S_RESP;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = S_DIV_Q;
               end
            end
         end
         S_DIV_Q: begin
            // append move and mid once the ratio is ready
            if (div_rsp.done) begin
               if (r_full) begin
                  r_head_in = r_head_ff + 1'b1;
                  ovf_in    = 1'b1;
               end else begin
                  r_cnt_in = r_cnt_ff + 1'b1;
               end
               if (m_full) begin
                  m_head_in = m_head_ff + 1'b1;
                  ovf_in    = 1'b1;
               end else begin
                  m_cnt_in = m_cnt_ff + 1'b1;
               end
               prev_mid_in = mid_ff;
               state_in    = S_TRIM_RD;
            end
         end
         S_TRIM_RD: begin
            state_in = S_TRIM_CMP;
         end
         S_TRIM_CMP: begin
            // drop stale front entries of both stores
            if (r_drop) begin
               r_head_in = r_head_ff + 1'b1;
               r_cnt_in  = r_cnt_ff - 1'b1;
            end
            if (m_drop) begin
               m_head_in = m_head_ff + 1'b1;
               m_cnt_in  = m_cnt_ff - 1'b1;
            end
            if (r_drop || m_drop) begin
               state_in = S_TRIM_RD;
            end else if ((op_ff == wvg_pkg::OP_CHECK) && time_pos) begin
               idx_in   = '0;
               pend_in  = 1'b0;
               state_in = S_WALK;
            end else begin
               state_in = S_RESP;
            end
         end
         S_WALK: begin
            // issue the next read
            if (idx_ff < max_cnt) begin
               pend_in       = 1'b1;
               pend_r_in     = idx_ff < r_cnt_ff;
               pend_m_in     = idx_ff < m_cnt_ff;
               pend_first_in = idx_ff == '0;
               idx_in        = idx_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            // fold in the word read last cycle
            if (pend_ff && pend_r_ff && (r_rd_data[RW-1:0] >= jthr_ff)) begin
               jumps_in = jumps_ff + 1'b1;
            end
            if (pend_ff && pend_m_ff) begin
               if (pend_first_ff) begin
                  lo_in = m_val;
                  hi_in = m_val;
               end else begin
                  lo_in = (m_val < lo_ff) ? m_val : lo_ff;
                  hi_in = (m_val > hi_ff) ? m_val : hi_ff;
               end
            end
            if (!pend_ff && (idx_ff >= max_cnt)) begin
               state_in = S_AMP;
            end
         end
         S_AMP: begin
            if (m_cnt_ff >= CW'(2)) begin
               div_req.start = 1'b1;
               div_req.num   = hi_ff - lo_ff;
               div_req.den   = lo_ff;
               state_in      = S_DIV_A;
            end else begin
               amp_in   = '0;
               state_in = S_DECIDE;
            end
         end
         S_DIV_A: begin
            if (div_rsp.done) begin
               amp_in   = div_rsp.quo;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // block on cooldown, or arm a new one when hot
            hot_in    = hot_now;
            active_in = active_now;
            if (active_now) begin
               block_in  = 1'b1;
               reason_in = wvg_pkg::REASON_COOLDOWN;
            end else if (hot_now) begin
               block_in    = 1'b1;
               reason_in   = wvg_pkg::REASON_TRIGGER;
               cooldown_in = cool_sum[TW] ? '1 : cool_sum[TW-1:0];
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         prev_mid_ff   <= '0;
         prev_valid_ff <= 1'b0;
         last_qt_ff    <= '0;
         cooldown_ff   <= '0;
         skip_ff       <= '0;
         ooo_ff        <= '0;
         ovf_ff        <= 1'b0;
         r_head_ff     <= '0;
         r_cnt_ff      <= '0;
         m_head_ff     <= '0;
         m_cnt_ff      <= '0;
         pend_ff       <= 1'b0;
         block_ff      <= 1'b0;
         reason_ff     <= wvg_pkg::REASON_NONE;
         hot_ff        <= 1'b0;
         active_ff     <= 1'b0;
         jumps_ff      <= '0;
         amp_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         prev_mid_ff   <= prev_mid_in;
         prev_valid_ff <= prev_valid_in;
         last_qt_ff    <= last_qt_in;
         cooldown_ff   <= cooldown_in;
         skip_ff       <= skip_in;
         ooo_ff        <= ooo_in;
         ovf_ff        <= ovf_in;
         r_head_ff     <= r_head_in;
         r_cnt_ff      <= r_cnt_in;
         m_head_ff     <= m_head_in;
         m_cnt_ff      <= m_cnt_in;
         pend_ff       <= pend_in;
         block_ff      <= block_in;
         reason_ff     <= reason_in;
         hot_ff        <= hot_in;
         active_ff     <= active_in;
         jumps_ff      <= jumps_in;
         amp_ff        <= amp_in;
      end
      op_ff         <= op_in;
      time_ff       <= time_in;
      mid_ff        <= mid_in;
      qvalid_ff     <= qvalid_in;
      r_cut_ff      <= r_cut_in;
      m_cut_ff      <= m_cut_in;
      idx_ff        <= idx_in;
      pend_r_ff     <= pend_r_in;
      pend_m_ff     <= pend_m_in;
      pend_first_ff <= pend_first_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
   end

   // drive the ports
   assign req_ready              = state_ff == S_IDLE;
   assign rsp_valid              = state_ff == S_RESP;
   assign rsp_blocked            = block_ff;
   assign rsp_block_reason       = reason_ff;
   assign rsp_jumps_in_window    = jumps_ff;
   assign rsp_amplitude          = amp_ff;
   assign rsp_hot                = hot_ff;
   assign rsp_cooling            = active_ff;
   assign rsp_cooldown_end       = cooldown_ff;
   assign rsp_skipped_total      = skip_ff;
   assign rsp_out_of_order_total = ooo_ff;
   assign rsp_store_overflow     = ovf_ff;

`ifndef ASSERT_OFF
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and response sides open together");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (r_cnt_ff <= CW'(wvg_pkg::WINDOW_DEPTH)) && (m_cnt_ff <= CW'(wvg_pkg::WINDOW_DEPTH)))
      else $error("store count beyond depth");

   a_block_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_blocked == (rsp_block_reason != wvg_pkg::REASON_NONE)))
      else $error("block flag and reason disagree");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV_Q || state_ff == S_DIV_A))
      else $error("divider finished outside a divide wait");
`endif

endmodule
